// ===== design/svt_pkg.sv =====
`default_nettype none

package svt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int VAL_W       = 32;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_SEARCH = 2'd3;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_FOUND     = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_REM
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic signed [VAL_W-1:0]  v;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/sorted_value_table_unit.sv =====
// Result: each accepted request's status and count are registered in the output register.
// Throughput: one request per cycle while in_stall is low; every cell of the chain compares against
// the broadcast value and shifts in the same cycle, and the count update closes the loop.
// Reset: arst_n clears the entry count and output valid; entry contents are
// not reset and are only read below the count.
`default_nettype none

module sorted_value_table_unit
	import svt_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [1:0]              req_type,
	input  wire logic signed [VAL_W-1:0] value,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [2:0]                   status,
	output logic [4:0]                   entry_count
);

	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	logic [2:0]            status_q;
	logic [CNT_W-1:0]      entry_count_q;
	logic [CNT_W+4:0]      cnt_ext;

	logic                  acc;
	logic                  full;
	logic                  empty;
	logic                  found;
	cell_ctrl_t            ctrl;
	logic [2:0]            status_d;
	logic [CNT_W-1:0]      count_d;

	logic signed [VAL_W-1:0] entries [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]  lt_v;
	logic [TABLE_DEPTH-1:0]  eq_v;

	assign in_stall = out_valid_q && out_stall;
	assign acc      = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(TABLE_DEPTH));
	assign empty    = (count_q == '0);
	assign found    = |eq_v;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		logic                    lt_l;
		logic signed [VAL_W-1:0] left_e;
		logic signed [VAL_W-1:0] right_e;

		if (g == 0) begin : g_first
			assign lt_l   = 1'b1;
			assign left_e = value;
		end else begin : g_mid
			assign lt_l   = lt_v[g-1];
			assign left_e = entries[g-1];
		end
		if (g == TABLE_DEPTH - 1) begin : g_last
			assign right_e = value;
		end else begin : g_notlast
			assign right_e = entries[g+1];
		end

		svt_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (CNT_W'(g) < count_q),
			.lt_left     (lt_l),
			.left_entry  (left_e),
			.right_entry (right_e),
			.entry       (entries[g]),
			.lt          (lt_v[g]),
			.eq          (eq_v[g])
		);
	end

	always_comb begin
		ctrl.v   = value;
		ctrl.op  = CELL_HOLD;
		count_d  = count_q;
		status_d = ST_DONE;
		unique case (req_type)
			REQ_CLEAR: begin
				count_d = '0;
			end
			REQ_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.op = acc ? CELL_INS : CELL_HOLD;
					count_d = count_q + 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (!found) begin
					status_d = ST_NOT_FOUND;
				end else begin
					ctrl.op = acc ? CELL_REM : CELL_HOLD;
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				if (empty)      status_d = ST_EMPTY;
				else if (found) status_d = ST_FOUND;
				else            status_d = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q      <= status_d;
			entry_count_q <= count_d;
		end
	end

	assign cnt_ext     = {5'b0, entry_count_q};
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = cnt_ext[4:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req_type == REQ_INSERT && full) |=>
		(status_q == ST_FULL && count_q == CNT_W'(TABLE_DEPTH)))
		else $error("insert into full table not refused");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req_type == REQ_CLEAR) |=>
		(count_q == '0 && entry_count_q == '0 && status_q == ST_DONE))
		else $error("clear did not empty the table");

	a_result_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (out_valid_q && entry_count_q == count_q))
		else $error("result register out of step with count");

endmodule

`default_nettype wire

// ===== design/svt_cell.sv =====
`default_nettype none

module svt_cell
	import svt_pkg::*;
(
	input  wire logic                    clk,
	input  wire cell_ctrl_t              ctrl,
	input  wire logic                    occ,
	input  wire logic                    lt_left,
	input  wire logic signed [VAL_W-1:0] left_entry,
	input  wire logic signed [VAL_W-1:0] right_entry,
	output logic signed [VAL_W-1:0]      entry,
	output logic                         lt,
	output logic                         eq
);

	logic signed [VAL_W-1:0] entry_q;

	assign entry = entry_q;
	assign lt    = occ && (entry_q < ctrl.v);
	assign eq    = occ && (entry_q == ctrl.v);

	// cells below the insert/remove point keep their entry; the rest shift
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_INS: begin
				if (!lt) entry_q <= lt_left ? ctrl.v : left_entry;
			end
			CELL_REM: begin
				if (!lt) entry_q <= right_entry;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sim/tb_sorted_value_table_unit.sv =====
`default_nettype none

module tb_sorted_value_table_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import svt_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 40;

	typedef struct {
		logic [2:0] status;
		logic [4:0] count;
	} reply_t;

	// shadow of the sorted table plus the queue of replies still owed by the block
	class sorted_table_scoreboard;
		logic signed [VAL_W-1:0] entries [TABLE_DEPTH];
		int unsigned             fill;
		reply_t                  replies_due [$];
		int unsigned             mismatches;

		function new();
			fill       = 0;
			mismatches = 0;
		endfunction

		function int unsigned find_value(logic signed [VAL_W-1:0] v);
			int unsigned idx;
			for (idx = 0; idx < fill; idx++)
				if (entries[idx] == v)
					return idx;
			return fill;
		endfunction

		function void note_request(logic [1:0] kind, logic signed [VAL_W-1:0] v);
			int unsigned pos;
			int unsigned idx;
			reply_t      r;
			r.status = ST_DONE;
			case (kind)
				REQ_CLEAR: begin
					fill = 0;
				end
				REQ_INSERT: begin
					if (fill >= TABLE_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						// duplicates land ahead of existing equal entries
						pos = 0;
						while (pos < fill && entries[pos] < v)
							pos++;
						for (idx = fill; idx > pos; idx--)
							entries[idx] = entries[idx-1];
						entries[pos] = v;
						fill++;
					end
				end
				REQ_REMOVE: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else begin
						pos = find_value(v);
						if (pos >= fill) begin
							r.status = ST_NOT_FOUND;
						end else begin
							for (idx = pos; idx + 1 < fill; idx++)
								entries[idx] = entries[idx+1];
							fill--;
						end
					end
				end
				default: begin
					if (fill == 0)
						r.status = ST_EMPTY;
					else if (find_value(v) < fill)
						r.status = ST_FOUND;
					else
						r.status = ST_NOT_FOUND;
				end
			endcase
			r.count = fill[4:0];
			replies_due.push_back(r);
		endfunction

		function void check_reply(logic [2:0] st, logic [4:0] cnt);
			reply_t r;
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected reply status %0d count %0d", $realtime, st, cnt);
				return;
			end
			r = replies_due.pop_front();
			if (st !== r.status || cnt !== r.count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: reply mismatch status exp %0d got %0d, count exp %0d got %0d",
						$realtime, r.status, st, r.count, cnt);
			end
		endfunction
	endclass

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    in_valid    = 1'b0;
	logic                    in_stall;
	logic [1:0]              req_type    = REQ_CLEAR;
	logic signed [VAL_W-1:0] value       = '0;
	logic                    out_valid;
	logic                    out_stall   = 1'b0;
	logic [2:0]              status;
	logic [4:0]              entry_count;

	sorted_table_scoreboard sb;
	bit tx_idle   = 1'b0;
	bit rx_idle   = 1'b0;
	int hold_len  = 0;
	int quiet_cycles = 0;

	sorted_value_table_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.entry_count (entry_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic send_item(input logic [1:0] kind, input logic signed [VAL_W-1:0] v);
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= kind;
		value    <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(kind, v);
	endtask

	task automatic sender_gap(input int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// mostly a small pool so that removes and searches hit stored entries
	task automatic send_random();
		logic [1:0]              kind;
		logic signed [VAL_W-1:0] v;
		int                      pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			kind = REQ_CLEAR;
		else if (pick < 44)
			kind = REQ_INSERT;
		else if (pick < 72)
			kind = REQ_REMOVE;
		else
			kind = REQ_SEARCH;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			v = $signed($urandom_range(0, 6)) - 3;
		else if (pick == 6)
			v = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			v = $urandom;
		send_item(kind, v);
		if (tx_idle && $urandom_range(0, 7) == 0)
			sender_gap($urandom_range(1, 11));
	endtask

	task automatic wait_drained();
		while (sb.replies_due.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stall bursts, or one long hold when requested
	initial begin
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
				out_stall <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// reply checks and the no-progress watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_reply(status, entry_count);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, extremes, duplicates, hits and misses, then fill up
		send_item(REQ_SEARCH, 32'sd5);
		send_item(REQ_REMOVE, 32'sd5);
		send_item(REQ_CLEAR, -32'sd1);
		send_item(REQ_INSERT, 32'sh7fff_ffff);
		send_item(REQ_INSERT, 32'sh8000_0000);
		send_item(REQ_INSERT, 32'sd0);
		send_item(REQ_INSERT, 32'sd0);
		send_item(REQ_INSERT, -32'sd1);
		send_item(REQ_SEARCH, 32'sd0);
		send_item(REQ_SEARCH, 32'sd1);
		send_item(REQ_REMOVE, 32'sd1);
		send_item(REQ_REMOVE, 32'sd0);
		repeat (12) send_item(REQ_INSERT, $urandom);
		send_item(REQ_INSERT, 32'sd7);
		send_item(REQ_SEARCH, 32'sh7fff_ffff);

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (800) send_random();

		// long receiver hold while the sender keeps pushing
		tx_idle  = 1'b0;
		hold_len = HOLD_CYCLES;
		repeat (30) send_random();

		sender_gap(1);
		wait_drained();

		tx_idle = 1'b1;
		repeat (200) send_random();

		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (200) send_random();

		sender_gap(1);
		wait_drained();
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0 && sb.replies_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
